@@ rtl/cpis_pkg.sv @@
// Package for the clock rate PI servo: field widths, register codes,
// reset values and saturation constants. No dependencies.
`default_nettype none

package cpis_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int X_W           = 32;
    localparam int SM_W          = 48;
    localparam int IS_W          = 40;
    localparam int GAIN_W        = 17;
    localparam int LIM_W         = 20;
    localparam int SETTLE_W      = 4;
    localparam int ADJ_W         = 11;
    localparam int Q_W           = 10;
    localparam int DIV_W         = 48;
    localparam int CW            = 50;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 20;
    localparam int DIV_PPM       = 1000;

    localparam logic [GAIN_W-1:0] ONE_Q16 = GAIN_W'(65536);

    localparam logic [CFG_IDX_W-1:0] REG_SMOOTHING_GAIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_GAIN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_LIMIT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_LIMIT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SETTLE_SAMPLES = 3'd4;

    localparam logic [GAIN_W-1:0]   RST_SMOOTHING_GAIN = GAIN_W'(13107);
    localparam logic [GAIN_W-1:0]   RST_INTEGRAL_GAIN  = GAIN_W'(131);
    localparam logic [LIM_W-1:0]    RST_INTEGRAL_LIMIT = LIM_W'(300000);
    localparam logic [LIM_W-1:0]    RST_OUTPUT_LIMIT   = LIM_W'(400000);
    localparam logic [SETTLE_W-1:0] RST_SETTLE_SAMPLES = SETTLE_W'(3);

    localparam logic signed [SM_W-1:0] SM_MAX = {1'b0, {(SM_W-1){1'b1}}};
    localparam logic signed [SM_W-1:0] SM_MIN = {1'b1, {(SM_W-1){1'b0}}};
    localparam logic signed [IS_W-1:0] IS_MIN = {1'b1, {(IS_W-1){1'b0}}};
    localparam logic [CW-1:0]          IN_MAX = CW'({(IS_W-1){1'b1}});

    function automatic int mcand_width(input int f);
        return (X_W + f > SM_W) ? X_W + f : SM_W;
    endfunction

endpackage

`default_nettype wire

@@ rtl/cpis_mul.sv @@
// Bit-serial Q1.16 gain multiplier: one gain bit per cycle, floor(g*m / 2^16).
// Depends on cpis_pkg.
`default_nettype none

module cpis_mul #(
    parameter int MW = cpis_pkg::mcand_width(cpis_pkg::FRAC_BITS_DEF)
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [cpis_pkg::GAIN_W-1:0]    i_gain,
    input  logic signed [MW-1:0]           i_mcand,
    output logic                           o_done,
    output logic signed [MW-1:0]           o_prod
);
    import cpis_pkg::*;

    localparam int CNT_W = $clog2(GAIN_W);

    logic signed [MW-1:0] r_m;
    logic [GAIN_W-1:0]    r_g;
    logic signed [MW:0]   r_acc;
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_busy;
    logic                 r_done;

    logic signed [MW:0]   add_term;
    logic signed [MW:0]   sum;
    logic                 last;

    assign add_term = r_g[0] ? (MW+1)'(r_m) : '0;
    assign sum      = r_acc + add_term;
    assign last     = (r_cnt == CNT_W'(GAIN_W - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_m    <= i_mcand;
                r_g    <= i_gain;
                r_acc  <= '0;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_g <= r_g >> 1;
                if (last) begin
                    r_acc  <= sum;
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_acc <= sum >>> 1;
                    r_cnt <= r_cnt + CNT_W'(1);
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = $signed(r_acc[MW-1:0]);

endmodule

`default_nettype wire

@@ rtl/cpis_div.sv @@
// Restoring serial divider: |c| / (1000 * 2^FRAC_BITS), one quotient bit per
// cycle, saturated at 1023. Depends on cpis_pkg.
`default_nettype none

module cpis_div #(
    parameter int FRAC_BITS = cpis_pkg::FRAC_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [cpis_pkg::DIV_W-1:0]  i_mag,
    output logic                        o_done,
    output logic [cpis_pkg::Q_W-1:0]    o_quot
);
    import cpis_pkg::*;

    localparam int CNT_W = $clog2(Q_W + 1);
    localparam logic [DIV_W-1:0] DIV_TOP = DIV_W'(DIV_PPM) << (FRAC_BITS + Q_W);

    logic [DIV_W-1:0] r_rem;
    logic [DIV_W-1:0] r_d;
    logic [Q_W-1:0]   r_q;
    logic             r_ovf;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic             ge;

    assign ge = (r_rem >= r_d);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_rem  <= i_mag;
                r_d    <= DIV_TOP;
                r_q    <= '0;
                r_ovf  <= 1'b0;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (ge) begin
                    r_rem <= r_rem - r_d;
                end
                r_d <= r_d >> 1;
                // first step only tests for a quotient of 1024 or more
                if (r_cnt == '0) begin
                    r_ovf <= ge;
                end else begin
                    r_q <= {r_q[Q_W-2:0], ge};
                end
                if (r_cnt == CNT_W'(Q_W)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + CNT_W'(1);
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_ovf ? '1 : r_q;

endmodule

`default_nettype wire

@@ rtl/clock_rate_pi_servo.sv @@
// Clock rate PI servo top level: config registers, sequencer, servo state.
// Depends on cpis_pkg, cpis_mul, cpis_div.
// Normal sample: three serial multiplies in cpis_mul, an 11-step serial divide
// in cpis_div, then sequencing; no new request is taken until the result has
// been handed to the output register (o_in_stall is high meanwhile).
// Step events and settling samples skip the multiplies and the divide.
// Reset (synchronous, active low): registers to defaults, servo state cleared.
`default_nettype none

module clock_rate_pi_servo #(
    parameter int FRAC_BITS = cpis_pkg::FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_action,
    input  logic signed [cpis_pkg::X_W-1:0]   i_rate_error_ppb,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [cpis_pkg::ADJ_W-1:0] o_adjust_ppm,
    output logic                              o_apply,
    output logic                              o_skipped,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [cpis_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [cpis_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import cpis_pkg::*;

    localparam int MW = mcand_width(FRAC_BITS);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_M1   = 4'd1;
    localparam logic [3:0] S_M2   = 4'd2;
    localparam logic [3:0] S_KI   = 4'd3;
    localparam logic [3:0] S_M3   = 4'd4;
    localparam logic [3:0] S_OUT  = 4'd5;
    localparam logic [3:0] S_ABS  = 4'd6;
    localparam logic [3:0] S_DIV  = 4'd7;
    localparam logic [3:0] S_FIN  = 4'd8;

    logic [GAIN_W-1:0]   r_alpha;
    logic [GAIN_W-1:0]   r_ki;
    logic [LIM_W-1:0]    r_il;
    logic [LIM_W-1:0]    r_ol;
    logic [SETTLE_W-1:0] r_ss;

    logic [3:0]              r_state;
    logic [3:0]              n_state;
    logic [SETTLE_W-1:0]     r_settle;
    logic signed [SM_W-1:0]  r_sm;
    logic signed [IS_W-1:0]  r_is;
    logic signed [MW-1:0]    r_t1;
    logic signed [CW-1:0]    r_c;
    logic                    r_neg;
    logic [ADJ_W-1:0]        r_res_adj;
    logic                    r_res_skip;
    logic                    r_ov;
    logic [ADJ_W-1:0]        r_out_adj;
    logic                    r_out_skip;

    logic                    in_accept;
    logic                    cfg_we;
    logic                    out_free;
    logic [GAIN_W-1:0]       alpha_g;
    logic [GAIN_W-1:0]       ki_g;
    logic [GAIN_W-1:0]       one_minus;
    logic signed [MW-1:0]    x_ext;
    logic signed [MW-1:0]    sm_ext;

    logic                    mul_start;
    logic [GAIN_W-1:0]       mul_gain;
    logic signed [MW-1:0]    mul_mcand;
    logic                    mul_done;
    logic signed [MW-1:0]    mul_prod;

    logic                    div_start;
    logic                    div_done;
    logic [Q_W-1:0]          div_quot;

    logic signed [MW:0]      sm_sum;
    logic [MW-SM_W+1:0]      sm_top;
    logic signed [SM_W-1:0]  sm_sat;
    logic signed [SM_W-1:0]  ki_term;
    logic signed [CW-1:0]    is_sum;
    logic [CW-1:0]           icap_raw;
    logic signed [CW-1:0]    icap;
    logic signed [CW-1:0]    is_sat;
    logic signed [CW-1:0]    c_sum;
    logic signed [CW-1:0]    ocap;
    logic signed [CW-1:0]    c_sat;
    logic signed [CW-1:0]    c_neg;
    logic [DIV_W-1:0]        c_mag;
    logic [ADJ_W-1:0]        q_ext;
    logic [ADJ_W-1:0]        adj;

    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;
    assign out_free    = !r_ov || !i_out_stall;

    assign alpha_g   = (r_alpha > ONE_Q16) ? ONE_Q16 : r_alpha;
    assign ki_g      = (r_ki > ONE_Q16) ? ONE_Q16 : r_ki;
    assign one_minus = ONE_Q16 - alpha_g;
    assign x_ext     = MW'(i_rate_error_ppb) <<< FRAC_BITS;
    assign sm_ext    = MW'(r_sm);

    // EMA sum, saturated to the smoothed-term width
    assign sm_sum = (MW+1)'(r_t1) + (MW+1)'(mul_prod);
    assign sm_top = sm_sum[MW:SM_W-1];
    always_comb begin
        if ((&sm_top) || !(|sm_top)) begin
            sm_sat = sm_sum[SM_W-1:0];
        end else if (sm_sum[MW]) begin
            sm_sat = SM_MIN;
        end else begin
            sm_sat = SM_MAX;
        end
    end

    // integral update with anti-windup bound
    assign ki_term  = mul_prod[SM_W-1:0];
    assign is_sum   = CW'(r_is) + CW'(ki_term);
    assign icap_raw = CW'(r_il) << FRAC_BITS;
    assign icap     = (icap_raw > IN_MAX) ? $signed(IN_MAX) : $signed(icap_raw);
    always_comb begin
        if (is_sum > icap) begin
            is_sat = icap;
        end else if (is_sum < -icap) begin
            is_sat = -icap;
        end else begin
            is_sat = is_sum;
        end
    end

    // combined correction bound
    assign c_sum = CW'(r_sm) + CW'(r_is);
    assign ocap  = $signed(CW'(r_ol) << FRAC_BITS);
    always_comb begin
        if (c_sum > ocap) begin
            c_sat = ocap;
        end else if (c_sum < -ocap) begin
            c_sat = -ocap;
        end else begin
            c_sat = c_sum;
        end
    end

    assign c_neg = -r_c;
    assign c_mag = r_c[CW-1] ? c_neg[DIV_W-1:0] : r_c[DIV_W-1:0];
    assign q_ext = ADJ_W'(div_quot);
    assign adj   = r_neg ? q_ext : -q_ext;

    always_comb begin
        mul_start = 1'b0;
        mul_gain  = alpha_g;
        mul_mcand = x_ext;
        case (r_state)
            S_IDLE: begin
                mul_start = in_accept && !i_action && (r_settle == '0);
            end
            S_M1: begin
                mul_start = mul_done;
                mul_gain  = one_minus;
                mul_mcand = sm_ext;
            end
            S_KI: begin
                mul_start = 1'b1;
                mul_gain  = ki_g;
                mul_mcand = sm_ext;
            end
            default: begin
                mul_start = 1'b0;
            end
        endcase
    end

    assign div_start = (r_state == S_ABS);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_state = (i_action || (r_settle != '0)) ? S_FIN : S_M1;
                end
            end
            S_M1:  n_state = mul_done ? S_M2 : S_M1;
            S_M2:  n_state = mul_done ? S_KI : S_M2;
            S_KI:  n_state = S_M3;
            S_M3:  n_state = mul_done ? S_OUT : S_M3;
            S_OUT: n_state = S_ABS;
            S_ABS: n_state = S_DIV;
            S_DIV: n_state = div_done ? S_FIN : S_DIV;
            S_FIN: n_state = out_free ? S_IDLE : S_FIN;
            default: n_state = S_IDLE;
        endcase
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha <= RST_SMOOTHING_GAIN;
            r_ki    <= RST_INTEGRAL_GAIN;
            r_il    <= RST_INTEGRAL_LIMIT;
            r_ol    <= RST_OUTPUT_LIMIT;
            r_ss    <= RST_SETTLE_SAMPLES;
        end else if (cfg_we) begin
            case (i_cfg_index)
                REG_SMOOTHING_GAIN: r_alpha <= i_cfg_data[GAIN_W-1:0];
                REG_INTEGRAL_GAIN:  r_ki    <= i_cfg_data[GAIN_W-1:0];
                REG_INTEGRAL_LIMIT: r_il    <= i_cfg_data[LIM_W-1:0];
                REG_OUTPUT_LIMIT:   r_ol    <= i_cfg_data[LIM_W-1:0];
                REG_SETTLE_SAMPLES: r_ss    <= i_cfg_data[SETTLE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // servo state and sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_settle <= '0;
            r_sm     <= '0;
            r_is     <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_res_adj  <= '0;
                        r_res_skip <= 1'b0;
                        if (i_action) begin
                            r_settle <= r_ss;
                            r_sm     <= '0;
                            r_is     <= '0;
                        end else if (r_settle != '0) begin
                            r_settle   <= r_settle - SETTLE_W'(1);
                            r_res_skip <= 1'b1;
                        end
                    end
                end
                S_M1: begin
                    if (mul_done) begin
                        r_t1 <= mul_prod;
                    end
                end
                S_M2: begin
                    if (mul_done) begin
                        r_sm <= sm_sat;
                    end
                end
                S_M3: begin
                    if (mul_done) begin
                        r_is <= is_sat[IS_W-1:0];
                    end
                end
                S_OUT: begin
                    r_c <= c_sat;
                end
                S_ABS: begin
                    r_neg <= r_c[CW-1];
                end
                S_DIV: begin
                    if (div_done) begin
                        r_res_adj <= adj;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else begin
            if (r_ov && !i_out_stall) begin
                r_ov <= 1'b0;
            end
            if ((r_state == S_FIN) && out_free) begin
                r_ov       <= 1'b1;
                r_out_adj  <= r_res_adj;
                r_out_skip <= r_res_skip;
            end
        end
    end

    assign o_out_valid  = r_ov;
    assign o_adjust_ppm = $signed(r_out_adj);
    assign o_apply      = (r_out_adj != '0);
    assign o_skipped    = r_out_skip;

    cpis_mul #(
        .MW        (MW)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_gain  (mul_gain),
        .i_mcand (mul_mcand),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    cpis_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_mag   (c_mag),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    a_apply_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_apply == (o_adjust_ppm != '0)))
        else $error("apply flag disagrees with correction");

    a_skip_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_skipped) |-> (o_adjust_ppm == '0))
        else $error("skipped result carries a correction");

    a_integral_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_is != IS_MIN)
        else $error("integral term beyond its bound");

    a_mul_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_done |-> (r_state == S_M1 || r_state == S_M2 || r_state == S_M3))
        else $error("multiplier finished outside a multiply step");

endmodule

`default_nettype wire
